[rtl/core/image_crc32c_header_validator_defines.svh]
// assertion macros for the image crc32c header validator
// used by the checker module; needs a clk and rst in scope where expanded
`ifndef IMAGE_CRC32C_HEADER_VALIDATOR_DEFINES_SVH
`define IMAGE_CRC32C_HEADER_VALIDATOR_DEFINES_SVH

// property checked at every clock edge outside reset
`define ICV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define ICV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/icv_pkg.sv]
// shared types, constants and the crc byte step for the image validator
// no dependencies; imported by every module of the block
package icv_pkg;

  // byte counter width
  localparam int COUNT_BITS = 24;
  localparam int LEN_W      = COUNT_BITS + 1;
  localparam int MIN_W      = 24;
  // width that holds both the image length and the minimum length
  localparam int CMP_W      = (LEN_W > MIN_W) ? LEN_W : MIN_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_WRAP = CNT_MAX - COUNT_BITS'(3);

  // header layout
  localparam logic [COUNT_BITS-1:0] HDR_LEN     = COUNT_BITS'(16);
  localparam logic [COUNT_BITS-1:0] HDR_VER_POS = COUNT_BITS'(14);
  localparam logic [7:0]            HDR_VER_A   = 8'h87;
  localparam logic [7:0]            HDR_VER_B   = 8'h56;

  // crc-32c, reflected form
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // reset value of the minimum length register
  localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(255 * 1024);

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SMALL = 2'd1,
    ST_CRC_BAD   = 2'd2,
    ST_HDR_BAD   = 2'd3
  } status_t;

  // one request held between the input register and the engine
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } icv_item_t;

  // one byte through the reflected crc, eight bit steps
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/icv_in_reg.sv]
// input register stage of the image validator
// depends on icv_pkg for the request struct
module icv_in_reg
  import icv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       item_valid,
  output icv_item_t  item,
  input  logic       item_take
);

  logic accept;

  // hold off the source while a request sits here and is not taken
  assign in_stall = item_valid && !item_take;
  assign accept   = in_valid && !in_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  // payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte <= data_byte;
      item.last_byte <= last_byte;
    end
  end

endmodule

[rtl/core/icv_engine.sv]
// stream state, checks and result register of the image validator
// depends on icv_pkg for constants, status codes and the crc byte step
module icv_engine
  import icv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [MIN_W-1:0] cfg_data,
  input  logic             item_valid,
  input  icv_item_t        item,
  output logic             item_take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [31:0]      crc_value
);

  logic [MIN_W-1:0]      min_image_bytes;
  logic [31:0]           crc_reg;
  logic [31:0]           crc_run;
  logic [COUNT_BITS-1:0] byte_count;
  logic [7:0]            header_sum;
  logic [7:0]            header_version_byte;

  logic [31:0]           crc_run_next;
  logic [31:0]           crc_reg_next;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [7:0]            header_sum_next;
  logic [7:0]            header_version_byte_next;
  logic [LEN_W-1:0]      length;
  logic                  ver_ok;
  status_t               status_next;
  logic                  out_free;

  // a last byte needs a free result slot, other bytes always go
  assign out_free  = !out_valid || !out_stall;
  assign item_take = item_valid && (!item.last_byte || out_free);

  // minimum length register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_image_bytes <= MIN_RESET;
    end else if (cfg_write) begin
      min_image_bytes <= cfg_data;
    end
  end

  // per byte update: crc runs byte-wise, commits on each full word
  always_comb begin
    crc_run_next = crc32c_byte(crc_run, item.data_byte);
    crc_reg_next = (byte_count[1:0] == 2'd3) ? crc_run_next : crc_reg;

    header_sum_next = (byte_count < HDR_LEN) ? header_sum + item.data_byte : header_sum;
    header_version_byte_next = (byte_count == HDR_VER_POS) ? item.data_byte
                                                           : header_version_byte;

    byte_count_next = (byte_count == CNT_MAX) ? CNT_WRAP : byte_count + COUNT_BITS'(1);
    length          = LEN_W'(byte_count) + LEN_W'(1);
  end

  // checks in priority order
  always_comb begin
    ver_ok = (header_version_byte_next == HDR_VER_A) ||
             (header_version_byte_next == HDR_VER_B);
    if (CMP_W'(length) < CMP_W'(min_image_bytes)) begin
      status_next = ST_TOO_SMALL;
    end else if (crc_reg_next != '0) begin
      status_next = ST_CRC_BAD;
    end else if (header_sum_next != '0 || !ver_ok) begin
      status_next = ST_HDR_BAD;
    end else begin
      status_next = ST_OK;
    end
  end

  // stream state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg             <= CRC_INIT;
      crc_run             <= CRC_INIT;
      byte_count          <= '0;
      header_sum          <= '0;
      header_version_byte <= '0;
    end else if (item_take) begin
      if (item.last_byte) begin
        crc_reg             <= CRC_INIT;
        crc_run             <= CRC_INIT;
        byte_count          <= '0;
        header_sum          <= '0;
        header_version_byte <= '0;
      end else begin
        crc_reg             <= crc_reg_next;
        crc_run             <= crc_run_next;
        byte_count          <= byte_count_next;
        header_sum          <= header_sum_next;
        header_version_byte <= header_version_byte_next;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take && item.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_take && item.last_byte) begin
      status    <= status_next;
      crc_value <= crc_reg_next;
    end
  end

endmodule

[rtl/core/image_crc32c_header_validator.sv]
// channel    dir  handshake               payload
// in         in   in_valid / in_stall     data_byte, last_byte
// out        out  out_valid / out_stall   status, crc_value
// cfg        in   cfg_valid / cfg_ready   cfg_data (min_image_bytes)
//
// one byte per cycle while no last byte waits on a stalled result
// the crc advances one byte per cycle through an eight step xor network
// rst is synchronous: it clears the stream state, the valid flags and the
// minimum length back to 261120 bytes
// a stalled result holds only last bytes at the engine; bytes behind them wait
//
// top level of the image validator; depends on icv_pkg, icv_in_reg, icv_engine
module image_crc32c_header_validator
  import icv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [31:0]      crc_value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MIN_W-1:0] cfg_data
);

  logic      item_valid;
  icv_item_t item;
  logic      item_take;

  // config writes land while no request is held
  assign cfg_ready = !item_valid;

  // input register
  icv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // crc, header checks and result register
  icv_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .crc_value  (crc_value)
  );

endmodule

[rtl/core/icv_checker.sv]
// port level checks for the image validator, bound to the top level
// depends on icv_pkg and image_crc32c_header_validator_defines.svh
`include "image_crc32c_header_validator_defines.svh"

module icv_port_checker
  import icv_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       status,
  input logic [31:0]      crc_value
);

  // a stalled result stays put
  `ICV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(crc_value), "result changed while stalled")

  // no result straight out of reset
  `ICV_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

  // an ok image has a zero crc residue
  `ICV_ASSERT(a_ok_crc, out_valid && status == ST_OK |-> crc_value == '0, "ok status with nonzero crc")

  // a crc failure has a nonzero residue
  `ICV_ASSERT(a_bad_crc, out_valid && status == ST_CRC_BAD |-> crc_value != '0, "crc status with zero crc")

endmodule

bind image_crc32c_header_validator icv_port_checker u_icv_checker (.*);
